FILE: src/wlpm_pkg.sv
// Shared types and constants for the window latency percentile monitor.
// No dependencies; imported by window_latency_percentile_monitor.
package wlpm_pkg;

  localparam int unsigned WINDOW_DEF = 64;
  localparam int unsigned TIME_W     = 48;
  localparam int unsigned VAL_W      = 56;
  localparam int unsigned STAGE_W    = 16;
  localparam int unsigned CODE_W     = 5;
  localparam int unsigned DISP_W     = 3;
  localparam int unsigned DISP_N     = 7;
  localparam int unsigned FRAC_W     = 8;
  localparam int unsigned RANK_N     = 3;
  localparam int unsigned PCT_W      = 7;

  localparam logic OP_OBSERVE  = 1'b0;
  localparam logic OP_SNAPSHOT = 1'b1;

  // Statistic codes
  localparam logic [CODE_W-1:0] CODE_WALL  = 5'd0;
  localparam logic [CODE_W-1:0] CODE_CPU   = 5'd8;
  localparam logic [CODE_W-1:0] CODE_DISP  = 5'd16;
  localparam logic [CODE_W-1:0] CODE_LAST  = 5'd22;
  localparam logic [2:0]        STAT_TOTAL = 3'd0;
  localparam logic [2:0]        STAT_COUNT = 3'd1;
  localparam logic [2:0]        STAT_MEAN  = 3'd7;

  localparam logic [PCT_W-1:0] PCT_HUNDRED = 7'd100;
  localparam logic [PCT_W-1:0] PCT_TAB [RANK_N] = '{7'd50, 7'd95, 7'd99};

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_INVALID  = 2'd1,
    STATUS_MISMATCH = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COUNT,
    ST_CAND,
    ST_CAND_LATCH,
    ST_SCAN,
    ST_PICK,
    ST_DIV_INIT,
    ST_DIV,
    ST_EMIT
  } state_e;

endpackage

FILE: src/window_latency_percentile_monitor.sv
// Window latency percentile monitor: ring window memory, snapshot sequencer
// with rank selection and a bit-serial mean divider. Depends on wlpm_pkg.
//
// Usage: an observe transaction yields one result with the status; when the
// status is OK it writes one slot of the ring memory. A snapshot transaction
// stalls the input while the sequencer works through the window memory
// (one synchronous read port with registered read data). With n filled slots
// it runs the counting sweep, then rank selection (each slot is compared
// against every slot, wall and CPU in the same pass), then up to two mean
// divisions (one quotient bit per cycle), then 23 result transactions, one
// per cycle when the output is not stalled. Percentile ranks are
// ceil(n*q/100), kept by incremental trackers during the counting sweep, so
// no divider is needed for them. The window is written only while idle, so
// the snapshot reads never overlap a write. The window has no reset; slots
// beyond the fill count are never read. Counters saturate at 2^48-1.
module window_latency_percentile_monitor
  import wlpm_pkg::*;
#(
  parameter int unsigned WINDOW = WINDOW_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write channel (stage_id)
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [STAGE_W-1:0]  cfg_data_i,
  // input transaction
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                opcode_i,
  input  logic                sample_ok_i,
  input  logic [STAGE_W-1:0]  sample_stage_i,
  input  logic [TIME_W-1:0]   wall_ns_i,
  input  logic                has_cpu_i,
  input  logic [TIME_W-1:0]   cpu_ns_i,
  input  logic [DISP_W-1:0]   disposition_i,
  // result transaction
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          status_o,
  output logic [CODE_W-1:0]   stat_code_o,
  output logic [VAL_W-1:0]    stat_value_o,
  output logic                present_o,
  output logic                last_o
);

  localparam int unsigned AW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CNT_W = $clog2(WINDOW + 1);
  localparam int unsigned MW    = 2 * TIME_W + 1;
  localparam int unsigned SUM_W = TIME_W + CNT_W;
  localparam int unsigned DIV_W = SUM_W + FRAC_W;
  localparam int unsigned DK_W  = $clog2(DIV_W + 1);
  localparam int unsigned PICK_N = 5;

  // Window memory: {cpu present, cpu, wall}
  logic [MW-1:0] mem_q [WINDOW];
  logic [MW-1:0] rd_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] rd_addr;

  state_e state_q, state_d;

  logic [STAGE_W-1:0] stage_q;
  logic [AW-1:0]      slot_q;
  logic [CNT_W-1:0]   filled_q;
  logic [TIME_W-1:0]  total_q, cpu_total_q;
  logic [TIME_W-1:0]  disp_q [DISP_N];

  // sweep control
  logic [CNT_W-1:0] a_q, i_q;
  logic             pend_q;
  logic             issue, sweep_done;

  // counting sweep
  logic [SUM_W-1:0] sum_q [2];
  logic [CNT_W-1:0] cnt_q [2];
  logic [CNT_W-1:0] rk_c_q [2][RANK_N];
  logic [PCT_W-1:0] rk_r_q [2][RANK_N];

  // rank selection
  logic [MW-1:0]    cand_q;
  logic [CNT_W-1:0] less_q [2];
  logic [CNT_W-1:0] le_q [2];
  logic [TIME_W-1:0] pick_q [2][PICK_N];
  logic [CNT_W-1:0] targ [2][PICK_N];

  // mean divider
  logic             dsel_q;
  logic [DIV_W-1:0] dq_q;
  logic [CNT_W-1:0] drem_q, dv_q;
  logic [DK_W-1:0]  dk_q;
  logic [CNT_W:0]   dtrial;
  logic             dbit;
  logic [VAL_W-1:0] mean_q [2];

  logic [4:0] e_q;

  // output register
  logic              out_valid_q;
  logic [1:0]        status_q;
  logic [CODE_W-1:0] code_q;
  logic [VAL_W-1:0]  value_q;
  logic              present_q, last_q;
  logic              out_free, in_acc, obs_acc, snap_acc, emit_load;
  status_e           obs_status;
  logic [VAL_W-1:0]  emit_value;
  logic              emit_present;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign obs_acc     = in_acc && (opcode_i == OP_OBSERVE);
  assign snap_acc    = in_acc && (opcode_i == OP_SNAPSHOT);

  always_comb begin
    if (!sample_ok_i) begin
      obs_status = STATUS_INVALID;
    end else if (sample_stage_i != stage_q) begin
      obs_status = STATUS_MISMATCH;
    end else begin
      obs_status = STATUS_OK;
    end
  end

  assign mem_we = obs_acc && (obs_status == STATUS_OK);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[slot_q] <= {has_cpu_i, (has_cpu_i ? cpu_ns_i : '0), wall_ns_i};
    end
    if (mem_re) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  // Rank targets: min, p50, p95, p99, max
  always_comb begin
    for (int s = 0; s < 2; s++) begin
      targ[s][0] = '0;
      for (int r = 0; r < RANK_N; r++) begin
        targ[s][r+1] = (rk_c_q[s][r] == '0) ? '0 : rk_c_q[s][r] - CNT_W'(1);
      end
      targ[s][4] = cnt_q[s] - CNT_W'(1);
    end
  end

  // Divider step
  assign dtrial = {drem_q, dq_q[DIV_W-1]};
  assign dbit   = (dtrial >= {1'b0, dv_q});

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:       if (snap_acc) state_d = ST_COUNT;
      ST_COUNT: begin
        if (sweep_done) state_d = (filled_q == '0) ? ST_EMIT : ST_CAND;
      end
      ST_CAND:       state_d = ST_CAND_LATCH;
      ST_CAND_LATCH: state_d = ST_SCAN;
      ST_SCAN:       if (sweep_done) state_d = ST_PICK;
      ST_PICK: begin
        state_d = (i_q + CNT_W'(1) == filled_q) ? ST_DIV_INIT : ST_CAND;
      end
      ST_DIV_INIT: begin
        if (cnt_q[dsel_q] != '0) begin
          state_d = ST_DIV;
        end else if (dsel_q) begin
          state_d = ST_EMIT;
        end
      end
      ST_DIV: begin
        if (dk_q == DK_W'(DIV_W - 1)) state_d = dsel_q ? ST_EMIT : ST_DIV_INIT;
      end
      ST_EMIT:       if (out_free && e_q == CODE_LAST) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    issue      = 1'b0;
    mem_re     = 1'b0;
    rd_addr    = a_q[AW-1:0];
    sweep_done = 1'b0;
    emit_load  = 1'b0;
    unique case (state_q)
      ST_COUNT, ST_SCAN: begin
        issue      = (a_q < filled_q);
        mem_re     = issue;
        sweep_done = !issue && !pend_q;
      end
      ST_CAND: begin
        mem_re  = 1'b1;
        rd_addr = i_q[AW-1:0];
      end
      ST_EMIT:  emit_load = out_free;
      default: ;
    endcase
  end

  // Result item selection during emit
  always_comb begin
    emit_value   = '0;
    emit_present = 1'b1;
    if (e_q >= CODE_DISP) begin
      emit_value = VAL_W'(disp_q[3'(e_q - CODE_DISP)]);
    end else begin
      unique case (e_q[2:0])
        STAT_TOTAL: emit_value = VAL_W'(e_q[3] ? cpu_total_q : total_q);
        STAT_COUNT: emit_value = VAL_W'(cnt_q[e_q[3]]);
        STAT_MEAN: begin
          emit_present = (cnt_q[e_q[3]] != '0);
          emit_value   = emit_present ? mean_q[e_q[3]] : '0;
        end
        default: begin
          emit_present = (cnt_q[e_q[3]] != '0);
          emit_value   = emit_present ?
                         VAL_W'(pick_q[e_q[3]][3'(e_q[2:0] - 3'd2)]) : '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      stage_q     <= '0;
      slot_q      <= '0;
      filled_q    <= '0;
      total_q     <= '0;
      cpu_total_q <= '0;
      for (int d = 0; d < DISP_N; d++) disp_q[d] <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      a_q         <= '0;
      i_q         <= '0;
      e_q         <= '0;
      dsel_q      <= 1'b0;
      dk_q        <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) stage_q <= cfg_data_i;

      // observe: advance ring and counters
      if (mem_we) begin
        slot_q <= (slot_q == AW'(WINDOW - 1)) ? '0 : slot_q + AW'(1);
        if (filled_q != CNT_W'(WINDOW)) filled_q <= filled_q + CNT_W'(1);
        if (total_q != '1) total_q <= total_q + TIME_W'(1);
        if (has_cpu_i && cpu_total_q != '1) cpu_total_q <= cpu_total_q + TIME_W'(1);
        for (int d = 0; d < DISP_N; d++) begin
          if (disposition_i == DISP_W'(d) && disp_q[d] != '1) begin
            disp_q[d] <= disp_q[d] + TIME_W'(1);
          end
        end
      end

      // sweep pointers
      pend_q <= issue;
      if (issue) a_q <= a_q + CNT_W'(1);
      if (snap_acc || state_q == ST_CAND_LATCH) a_q <= '0;
      if (snap_acc) i_q <= '0;
      if (state_q == ST_PICK) i_q <= i_q + CNT_W'(1);

      // divider sequencing
      if (snap_acc) dsel_q <= 1'b0;
      if (state_q == ST_DIV_INIT) begin
        dk_q <= '0;
        if (cnt_q[dsel_q] == '0) dsel_q <= 1'b1;
      end
      if (state_q == ST_DIV) begin
        dk_q <= dk_q + DK_W'(1);
        if (dk_q == DK_W'(DIV_W - 1)) dsel_q <= 1'b1;
      end

      // output register
      if (obs_acc || emit_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (snap_acc) e_q <= '0;
      if (emit_load) e_q <= e_q + CODE_W'(1);
    end
  end

  // Datapath registers without reset
  always_ff @(posedge clk_i) begin
    if (obs_acc) begin
      status_q  <= obs_status;
      code_q    <= CODE_WALL;
      value_q   <= '0;
      present_q <= 1'b0;
      last_q    <= 1'b1;
    end else if (emit_load) begin
      status_q  <= STATUS_OK;
      code_q    <= e_q;
      value_q   <= emit_value;
      present_q <= emit_present;
      last_q    <= (e_q == CODE_LAST);
    end

    // counting sweep: sums, set sizes, rank trackers
    if (snap_acc) begin
      for (int s = 0; s < 2; s++) begin
        sum_q[s] <= '0;
        cnt_q[s] <= '0;
        for (int r = 0; r < RANK_N; r++) begin
          rk_c_q[s][r] <= '0;
          rk_r_q[s][r] <= '0;
        end
      end
    end else if (state_q == ST_COUNT && pend_q) begin
      for (int s = 0; s < 2; s++) begin
        if (s == 0 || rd_q[MW-1]) begin
          sum_q[s] <= sum_q[s] + SUM_W'(rd_q[s*TIME_W +: TIME_W]);
          cnt_q[s] <= cnt_q[s] + CNT_W'(1);
          for (int r = 0; r < RANK_N; r++) begin
            if (rk_r_q[s][r] >= PCT_TAB[r]) begin
              rk_r_q[s][r] <= rk_r_q[s][r] - PCT_TAB[r];
            end else begin
              rk_r_q[s][r] <= rk_r_q[s][r] + PCT_HUNDRED - PCT_TAB[r];
              rk_c_q[s][r] <= rk_c_q[s][r] + CNT_W'(1);
            end
          end
        end
      end
    end

    // rank selection: count smaller and not-larger slots per candidate
    if (state_q == ST_CAND_LATCH) begin
      cand_q <= rd_q;
      for (int s = 0; s < 2; s++) begin
        less_q[s] <= '0;
        le_q[s]   <= '0;
      end
    end else if (state_q == ST_SCAN && pend_q) begin
      for (int s = 0; s < 2; s++) begin
        if (s == 0 || rd_q[MW-1]) begin
          if (rd_q[s*TIME_W +: TIME_W] < cand_q[s*TIME_W +: TIME_W]) begin
            less_q[s] <= less_q[s] + CNT_W'(1);
          end
          if (rd_q[s*TIME_W +: TIME_W] <= cand_q[s*TIME_W +: TIME_W]) begin
            le_q[s] <= le_q[s] + CNT_W'(1);
          end
        end
      end
    end
    if (state_q == ST_PICK) begin
      for (int s = 0; s < 2; s++) begin
        if (s == 0 || cand_q[MW-1]) begin
          for (int t = 0; t < PICK_N; t++) begin
            if (less_q[s] <= targ[s][t] && targ[s][t] < le_q[s]) begin
              pick_q[s][t] <= cand_q[s*TIME_W +: TIME_W];
            end
          end
        end
      end
    end

    // mean: floor(sum * 256 / count), one quotient bit per cycle
    if (state_q == ST_DIV_INIT) begin
      dq_q   <= {sum_q[dsel_q], FRAC_W'(0)};
      dv_q   <= cnt_q[dsel_q];
      drem_q <= '0;
    end else if (state_q == ST_DIV) begin
      drem_q <= dbit ? CNT_W'(dtrial - {1'b0, dv_q}) : dtrial[CNT_W-1:0];
      dq_q   <= {dq_q[DIV_W-2:0], dbit};
      if (dk_q == DK_W'(DIV_W - 1)) mean_q[dsel_q] <= {dq_q[VAL_W-2:0], dbit};
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign stat_code_o  = code_q;
  assign stat_value_o = value_q;
  assign present_o    = present_q;
  assign last_o       = last_q;

  // Input stays stalled while a snapshot is in progress
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o)
    else $error("input accepted during snapshot");

  // Window is never written during a snapshot sweep
  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_IDLE))
    else $error("window write outside idle");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= CNT_W'(WINDOW))
    else $error("fill count beyond window");

  // Snapshot always ends with the final disposition item marked last
  a_last_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_load && e_q == CODE_LAST) |=> (last_q && code_q == CODE_LAST))
    else $error("last flag mismatch");

endmodule
